>>> src/lnedit_pkg.sv
// ----------------------------------------------------------------------------
// lnedit_pkg
// Shared types and constants of the line editor: key codes, echo actions,
// command kinds passed from front to back, and configuration indexes.
// ----------------------------------------------------------------------------
package lnedit_pkg;

  localparam int unsigned ColW     = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [ColW-1:0] WrapReset  = 6'd40;
  localparam logic [ColW-1:0] StartReset = 6'd24;

  localparam logic [7:0] KeyErase = 8'h7F;
  localparam logic [7:0] KeyKill  = 8'h15;
  localparam logic [7:0] KeyWord  = 8'h17;
  localparam logic [7:0] KeyEnd   = 8'h04;
  localparam logic [7:0] KeySpace = 8'h20;
  localparam logic [7:0] KeyTilde = 8'h7E;

  typedef enum logic [2:0] {
    ACT_ECHO    = 3'd0,
    ACT_BELL    = 3'd1,
    ACT_RUBOUT  = 3'd2,
    ACT_NEWLINE = 3'd3,
    ACT_END     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    CMD_PRINT = 3'd0,
    CMD_ERASE = 3'd1,
    CMD_KILL  = 3'd2,
    CMD_WORD  = 3'd3,
    CMD_END   = 3'd4,
    CMD_BELL  = 3'd5
  } cmd_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WRAP_WIDTH   = 1'b0,
    CFG_START_COLUMN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] key;
  } cmd_t;

  typedef struct packed {
    logic            load;
    logic [ColW-1:0] value;
  } col_load_t;

endpackage

>>> src/lnedit_if.sv
// ----------------------------------------------------------------------------
// lnedit_if
// Valid/ready channels of the line editor: typed keys in, echo actions out.
// ----------------------------------------------------------------------------
interface lnedit_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink   (input valid, input key_byte, output ready);
endinterface

interface lnedit_echo_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output action, output out_byte, output last, input ready);
  modport sink   (input valid, input action, input out_byte, input last, output ready);
endinterface

>>> src/lnedit_front.sv
// ----------------------------------------------------------------------------
// lnedit_front
// Key intake: takes one byte per transfer, decodes it into a command kind
// and holds it in a register stage toward the command queue.
// ----------------------------------------------------------------------------
module lnedit_front import lnedit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lnedit_key_if.sink  key_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  function automatic cmd_kind_e classify(input logic [7:0] k);
    cmd_kind_e kind;
    if (k == KeyErase)                        kind = CMD_ERASE;
    else if (k == KeyKill)                    kind = CMD_KILL;
    else if (k == KeyWord)                    kind = CMD_WORD;
    else if (k == KeyEnd)                     kind = CMD_END;
    else if (k >= KeySpace && k <= KeyTilde)  kind = CMD_PRINT;
    else                                      kind = CMD_BELL;
    return kind;
  endfunction

  logic stg_vld_q;
  cmd_t stg_q;
  logic take;

  assign key_i.ready = !stg_vld_q || cmd_ready_i;
  assign take        = key_i.valid && key_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (take) begin
      stg_vld_q <= 1'b1;
    end else if (cmd_ready_i) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stg_q.kind <= classify(key_i.key_byte);
      stg_q.key  <= key_i.key_byte;
    end
  end

  assign cmd_valid_o = stg_vld_q;
  assign cmd_o       = stg_q;

endmodule

>>> src/lnedit_queue.sv
// ----------------------------------------------------------------------------
// lnedit_queue
// Short command queue between key intake and the edit sequencer.
// ----------------------------------------------------------------------------
module lnedit_queue import lnedit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            ent_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= bump(wr_ptr_q);
      if (pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (push && !pop)      count_q <= count_q + CntW'(1);
      else if (pop && !push) count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> src/lnedit_back.sv
// ----------------------------------------------------------------------------
// lnedit_back
// Edit sequencer: owns the line store, cursor, column and ended flag,
// scans the store backward for word boundaries and streams echo actions.
// ----------------------------------------------------------------------------
module lnedit_back import lnedit_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  input  logic [ColW-1:0]  wrap_width_i,
  input  col_load_t        col_load_i,
  lnedit_echo_if.source    echo_o
);

  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CW   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CmpW = (CW > ColW) ? CW : ColW;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_RUB  = 6'b000100,
    ST_NL   = 6'b001000,
    ST_ECHO = 6'b010000,
    ST_CHAR = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cursor_q, cursor_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [ColW-1:0] column_q, column_d;
  logic            ended_q, ended_d;
  logic            wrapm_q, wrapm_d;
  logic            skip_q, skip_d;
  logic            found_q, found_d;
  logic [7:0]      key_q, key_d;

  logic [7:0]      store_q [STORE_DEPTH];
  logic [7:0]      rd_q;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;

  logic            out_vld_q;
  action_e         out_act_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            emit_ok, emit, emit_last;
  action_e         emit_act;
  logic [7:0]      emit_byte;

  logic            rd_sp, step_dec, wrap_ok;
  logic [CW-1:0]   word_len;

  function automatic logic [ColW-1:0] dec_col(input logic [ColW-1:0] c);
    return (c == '0) ? '0 : c - ColW'(1);
  endfunction

  assign emit_ok  = !out_vld_q || echo_o.ready;
  assign rd_sp    = (rd_q == KeySpace);
  // wrap scan stops at a space; word erase skips trailing spaces first
  assign step_dec = wrapm_q ? !rd_sp : (skip_q || !rd_sp);
  assign word_len = cursor_q - idx_q;
  assign wrap_ok  = found_q && (CmpW'(word_len) < CmpW'(wrap_width_i));

  always_comb begin
    state_d   = state_q;
    cursor_d  = cursor_q;
    idx_d     = idx_q;
    column_d  = column_q;
    ended_d   = ended_q;
    wrapm_d   = wrapm_q;
    skip_d    = skip_q;
    found_d   = found_q;
    key_d     = key_q;
    cmd_ready_o = 1'b0;
    mem_we    = 1'b0;
    emit      = 1'b0;
    emit_act  = ACT_ECHO;
    emit_byte = '0;
    emit_last = 1'b0;
    rd_addr   = AW'(cursor_q - CW'(1));

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && emit_ok) begin
          cmd_ready_o = 1'b1;
          if (!ended_q) begin
            unique case (cmd_i.kind)
              CMD_END: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                if (cursor_q == '0) begin
                  emit_act = ACT_END;
                  ended_d  = 1'b1;
                end else begin
                  emit_act = ACT_BELL;
                end
              end
              CMD_ERASE: begin
                if (cursor_q != '0) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_act  = ACT_RUBOUT;
                  cursor_d  = cursor_q - CW'(1);
                  column_d  = dec_col(column_q);
                end
              end
              CMD_KILL: begin
                column_d = '0;
                if (cursor_q != '0) begin
                  idx_d   = '0;
                  state_d = ST_RUB;
                end
              end
              CMD_WORD: begin
                if (cursor_q != '0) begin
                  idx_d   = cursor_q;
                  wrapm_d = 1'b0;
                  skip_d  = 1'b1;
                  state_d = ST_SCAN;
                end
              end
              CMD_PRINT: begin
                if (cursor_q == CW'(STORE_DEPTH)) begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  emit_act  = ACT_BELL;
                end else begin
                  mem_we   = 1'b1;
                  cursor_d = cursor_q + CW'(1);
                  key_d    = cmd_i.key;
                  if (column_q < wrap_width_i) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_byte = cmd_i.key;
                    column_d  = column_q + ColW'(1);
                  end else begin
                    wrapm_d = 1'b1;
                    if (cmd_i.key == KeySpace) begin
                      found_d = 1'b1;
                      idx_d   = cursor_q + CW'(1);
                      state_d = ST_NL;
                    end else if (cursor_q == '0) begin
                      found_d = 1'b0;
                      state_d = ST_NL;
                    end else begin
                      idx_d   = cursor_q;
                      state_d = ST_SCAN;
                    end
                  end
                end
              end
              default: begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_act  = ACT_BELL;
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        // rd_q holds store[idx-1]; fetch store[idx-2] ahead
        rd_addr = AW'(idx_q - CW'(2));
        if (!step_dec) begin
          found_d = 1'b1;
          state_d = wrapm_q ? ST_NL : ST_RUB;
        end else begin
          if (!rd_sp) skip_d = 1'b0;
          found_d = 1'b0;
          idx_d   = idx_q - CW'(1);
          if (idx_q == CW'(1)) state_d = wrapm_q ? ST_NL : ST_RUB;
        end
      end
      ST_RUB: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_act = ACT_RUBOUT;
          cursor_d = cursor_q - CW'(1);
          column_d = dec_col(column_q);
          if ((cursor_q - CW'(1)) == idx_q) begin
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_NL: begin
        rd_addr = AW'(idx_q);
        if (emit_ok) begin
          emit     = 1'b1;
          emit_act = ACT_NEWLINE;
          if (wrap_ok) begin
            column_d = ColW'(word_len);
            if (word_len == '0) begin
              emit_last = 1'b1;
              state_d   = ST_IDLE;
            end else begin
              state_d = ST_ECHO;
            end
          end else begin
            state_d = ST_CHAR;
          end
        end
      end
      ST_ECHO: begin
        rd_addr = AW'(idx_q);
        if (emit_ok) begin
          emit      = 1'b1;
          emit_byte = rd_q;
          idx_d     = idx_q + CW'(1);
          rd_addr   = AW'(idx_q + CW'(1));
          if ((idx_q + CW'(1)) == cursor_q) begin
            emit_last = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end
      ST_CHAR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_byte = key_q;
          column_d  = ColW'(1);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (col_load_i.load) column_d = col_load_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cursor_q  <= '0;
      column_q  <= StartReset;
      ended_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      column_q <= column_d;
      ended_q  <= ended_d;
      if (emit)              out_vld_q <= 1'b1;
      else if (echo_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    wrapm_q <= wrapm_d;
    skip_q  <= skip_d;
    found_q <= found_d;
    key_q   <= key_d;
    if (emit) begin
      out_act_q  <= emit_act;
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  // line store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[AW'(cursor_q)] <= cmd_i.key;
    rd_q <= store_q[rd_addr];
  end

  assign echo_o.valid    = out_vld_q;
  assign echo_o.action   = out_act_q;
  assign echo_o.out_byte = out_byte_q;
  assign echo_o.last     = out_last_q;

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CW'(STORE_DEPTH))
    else $error("cursor beyond store depth");

  a_ended_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |=> ended_q)
    else $error("ended flag cleared");

  a_ended_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> !emit)
    else $error("result after session end");

  a_scan_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q != '0)
    else $error("scan below start of line");

  a_rub_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUB |-> idx_q < cursor_q)
    else $error("rubout target not below cursor");

endmodule

>>> src/line_editor_with_word_wrap.sv
// ----------------------------------------------------------------------------
// line_editor_with_word_wrap
// Terminal line editor with word wrap: typed bytes in, echo actions out.
// ----------------------------------------------------------------------------
// Each key byte arrives on key_i and yields zero or more echo actions on
// echo_o, the final one flagged by last. Printable bytes are stored and
// echoed; erase, kill and word erase answer with one rubout per removed
// byte; ctrl-d on an empty line ends the session, after which keys are
// swallowed. Once the display column reaches wrap_width, the next printable
// byte starts a new line and replays the partial word after the last space.
// Keys are taken one per cycle into a two-entry command queue, so typing
// never waits on the echo side until the queue fills. The edit sequencer
// works through one command at a time and takes each in its idle state: a
// plain key, erase, bell or end needs nothing more; kill then rubs out
// every stored byte; word erase scans back over the word and rubs it out;
// a wrap looks back for the last space, emits the newline and replays the
// partial word (or echoes the lone key). The scan and the replay share the
// single read port of the line store and use it one byte a cycle, the
// replay only while echo_o does not stall.
// Configuration: register 0 is wrap_width, register 1 is start_column
// (writing it also loads the current column).
// ----------------------------------------------------------------------------
module line_editor_with_word_wrap import lnedit_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lnedit_key_if.sink          key_i,
  lnedit_echo_if.source       echo_o
);

  // wrap width register; start column only matters as a column load
  logic [ColW-1:0] wrap_q;
  col_load_t       col_load;

  // front stage to queue
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;

  // queue to sequencer
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= WrapReset;
    end else if (cfg_we_i && cfg_idx_i == CFG_WRAP_WIDTH) begin
      wrap_q <= ColW'(cfg_data_i);
    end
  end

  // a start column write moves the cursor's display column right away
  assign col_load.load  = cfg_we_i && (cfg_idx_i == CFG_START_COLUMN);
  assign col_load.value = ColW'(cfg_data_i);

  // key intake and decode
  lnedit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // decouples intake from the sequencer
  lnedit_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  // line store, cursor, column and echo output register
  lnedit_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_ready_o  (q_ready),
    .cmd_i        (q_cmd),
    .wrap_width_i (wrap_q),
    .col_load_i   (col_load),
    .echo_o       (echo_o)
  );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line editor with word wrap. Keys go in over a
// valid/ready channel in random bursts while the echo side stalls on its own
// pattern. A cycle-accurate-free behavioral copy of the editor predicts every
// echo transfer, and each observed transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import lnedit_pkg::*;

  localparam int unsigned StoreDepth   = 64;
  localparam int unsigned ClkPeriod    = 4;
  localparam int unsigned ResetCycles  = 11;
  // worst case work of one command: scan back, newline, replay
  localparam int unsigned SettleCycles = 2 * StoreDepth + 40;
  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseKeys    = 22;
  localparam int unsigned FillKeys     = 68;

  // how a row of the directed table is applied and checked
  typedef enum logic [2:0] {
    ROW_KEY_MODEL,  // key, echoes come from the behavioral copy
    ROW_KEY_NONE,   // key, no echo at all
    ROW_KEY_ONE,    // key, exactly the one echo typed in the row
    ROW_WRAP,       // write wrap_width
    ROW_START       // write start_column
  } row_kind_e;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_LIGHT,
    SINK_HEAVY
  } sink_mode_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] data;
    action_e    act;
    logic [7:0] echo;
  } stim_row_t;

  typedef struct {
    action_e    act;
    logic [7:0] data;
    logic       last;
  } echo_t;

  // clock, reset and config port
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  lnedit_key_if  key_ch ();
  lnedit_echo_if echo_ch ();

  line_editor_with_word_wrap #(
    .STORE_DEPTH (StoreDepth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_i      (key_ch),
    .echo_o     (echo_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // behavioral copy of the editor state
  logic [7:0]  line_copy [StoreDepth];
  int          line_len   = 0;
  int          col_now    = StartReset;
  int          wrap_at    = WrapReset;
  bit          session_over = 1'b0;

  echo_t       echo_burst [$];   // echoes of the key just taken
  echo_t       echo_expect [$];  // echoes still owed by the block

  // bench bookkeeping
  row_kind_e   drv_row  = ROW_KEY_MODEL;
  action_e     drv_act  = ACT_ECHO;
  logic [7:0]  drv_echo = 8'h00;
  sink_mode_e  sink_mode = SINK_STEADY;
  int unsigned burst_left = 0;
  int unsigned keys_sent  = 0;
  int unsigned fail_cnt   = 0;
  int unsigned cycle_cnt  = 0;

  function automatic void add_echo(input action_e act, input logic [7:0] data);
    echo_burst.push_back('{act, data, 1'b0});
  endfunction

  // apply one key to the behavioral copy, leave its echoes in echo_burst
  function automatic void edit_line(input logic [7:0] key);
    int i;
    echo_burst.delete();
    if (!session_over) begin
      if (key == KeyEnd && line_len == 0) begin
        // ctrl-d on an empty line closes the session for good
        session_over = 1'b1;
        add_echo(ACT_END, 8'h00);
      end else if (key == KeyErase) begin
        if (line_len > 0) begin
          line_len--;
          col_now = (col_now > 0) ? col_now - 1 : 0;
          add_echo(ACT_RUBOUT, 8'h00);
        end
      end else if (key == KeyKill) begin
        while (line_len > 0) begin
          line_len--;
          add_echo(ACT_RUBOUT, 8'h00);
        end
        col_now = 0;
      end else if (key == KeyWord) begin
        // skip trailing spaces, then the word itself
        i = line_len;
        while (i > 0 && line_copy[i-1] == KeySpace) i--;
        while (i > 0 && line_copy[i-1] != KeySpace) i--;
        while (line_len > i) begin
          line_len--;
          col_now = (col_now > 0) ? col_now - 1 : 0;
          add_echo(ACT_RUBOUT, 8'h00);
        end
      end else if (key < KeySpace || key > KeyTilde) begin
        add_echo(ACT_BELL, 8'h00);
      end else if (line_len >= StoreDepth) begin
        add_echo(ACT_BELL, 8'h00);
      end else begin
        line_copy[line_len] = key;
        line_len++;
        if (col_now >= wrap_at) begin
          // i ends one past the last space, or at zero without a space
          i = line_len;
          while (i > 0 && line_copy[i-1] != KeySpace) i--;
          add_echo(ACT_NEWLINE, 8'h00);
          if (i > 0 && line_len - i < wrap_at) begin
            for (int k = i; k < line_len; k++) add_echo(ACT_ECHO, line_copy[k]);
            col_now = line_len - i;
          end else begin
            add_echo(ACT_ECHO, key);
            col_now = 1;
          end
        end else begin
          add_echo(ACT_ECHO, key);
          col_now = (col_now + 1) % 64;
        end
      end
      if (echo_burst.size() > 0) echo_burst[echo_burst.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
      fail_cnt++;
    end
  endfunction

  // everything is sampled at the rising edge in one process, so a key
  // transfer is always booked before any echo transfer of the same edge
  always @(posedge clk_i) begin : l_scoreboard
    echo_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WRAP_WIDTH:   wrap_at = cfg_data_i;
          CFG_START_COLUMN: col_now = cfg_data_i;  // start column also loads column
          default: ;
        endcase
      end
      if (key_ch.valid && key_ch.ready) begin
        edit_line(key_ch.key_byte);
        case (drv_row)
          ROW_KEY_NONE: ;
          ROW_KEY_ONE:  echo_expect.push_back('{drv_act, drv_echo, 1'b1});
          default:      foreach (echo_burst[n]) echo_expect.push_back(echo_burst[n]);
        endcase
      end
      if (echo_ch.valid && echo_ch.ready) begin
        if (echo_expect.size() == 0) begin
          $display("%0t: expected no echo, actual action %0d byte %02h last %0b",
                   $time, echo_ch.action, echo_ch.out_byte, echo_ch.last);
          fail_cnt++;
        end else begin
          want = echo_expect.pop_front();
          check_field("action", want.act, echo_ch.action);
          check_field("out_byte", want.data, echo_ch.out_byte);
          check_field("last", want.last, echo_ch.last);
        end
      end
    end
  end

  // run guard
  always @(posedge clk_i) begin : l_watchdog
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // echo side: ready drops on a pattern chosen per phase
  initial begin : l_echo_sink
    int unsigned stall;
    echo_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        echo_ch.ready <= 1'b0;
        stall--;
      end else begin
        echo_ch.ready <= 1'b1;
        case (sink_mode)
          SINK_LIGHT: if ($urandom_range(0, 99) < 25) stall = $urandom_range(1, 3);
          SINK_HEAVY: if ($urandom_range(0, 99) < 50) stall = $urandom_range(2, 10);
          default: ;
        endcase
      end
    end
  end

  // one key transfer; called and returns at a falling edge
  task automatic send_key(input logic [7:0] key);
    int unsigned gap;
    key_ch.valid    <= 1'b1;
    key_ch.key_byte <= key;
    do @(posedge clk_i); while (!key_ch.ready);
    @(negedge clk_i);
    keys_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      // end of burst: mostly short gaps, now and then a long quiet spell
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      key_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // hold keys off until every owed echo is in and the sequencer has settled
  task automatic wait_idle;
    key_ch.valid <= 1'b0;
    while (echo_expect.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_rows(input stim_row_t rows[$]);
    foreach (rows[r]) begin
      case (rows[r].kind)
        ROW_WRAP: begin
          wait_idle();
          cfg_write(CFG_WRAP_WIDTH, rows[r].data[CfgDataW-1:0]);
        end
        ROW_START: begin
          wait_idle();
          cfg_write(CFG_START_COLUMN, rows[r].data[CfgDataW-1:0]);
        end
        default: begin
          drv_row  = rows[r].kind;
          drv_act  = rows[r].act;
          drv_echo = rows[r].echo;
          send_key(rows[r].data);
        end
      endcase
    end
    drv_row = ROW_KEY_MODEL;
  endtask

  // one random unit: mostly words with a trailing space, plus editing keys
  // and noise; ctrl-d only goes out on a non-empty line
  task automatic type_random;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  key;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      repeat (len) send_key(8'($urandom_range(8'h21, KeyTilde)));
      if ($urandom_range(0, 3) != 0) send_key(KeySpace);
    end else if (pick < 65) begin
      send_key(8'($urandom_range(KeySpace, KeyTilde)));
    end else if (pick < 75) begin
      send_key(KeyErase);
    end else if (pick < 81) begin
      send_key(KeyWord);
    end else if (pick < 85) begin
      send_key(KeyKill);
    end else if (pick < 90 && line_len > 0) begin
      send_key(KeyEnd);
    end else begin
      key = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h1F))
                                 : 8'($urandom_range(8'h80, 8'hFF));
      if (key == KeyEnd) key = 8'h00;
      send_key(key);
    end
  endtask

  initial begin : l_main
    stim_row_t   opening [$];
    stim_row_t   closing [$];
    int unsigned phase_base;
    logic [CfgDataW-1:0] wrap_val;
    logic [CfgDataW-1:0] start_val;

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WRAP_WIDTH;
    cfg_data_i      = '0;
    key_ch.valid    = 1'b0;
    key_ch.key_byte = 8'h00;

    opening = '{
      // reset settings: wrap at 40, prompt takes 24 columns
      '{ROW_KEY_NONE,  KeyErase, ACT_ECHO,    8'h00},     // erase on empty line
      '{ROW_KEY_NONE,  KeyWord,  ACT_ECHO,    8'h00},     // word erase on empty line
      '{ROW_KEY_ONE,   8'h00,    ACT_BELL,    8'h00},
      '{ROW_KEY_ONE,   8'hFF,    ACT_BELL,    8'h00},
      '{ROW_KEY_ONE,   8'h1F,    ACT_BELL,    8'h00},     // just below space
      '{ROW_KEY_ONE,   8'h80,    ACT_BELL,    8'h00},
      '{ROW_KEY_ONE,   8'h41,    ACT_ECHO,    8'h41},
      '{ROW_KEY_ONE,   KeyEnd,   ACT_BELL,    8'h00},     // ctrl-d with text
      '{ROW_KEY_ONE,   KeySpace, ACT_ECHO,    KeySpace},
      '{ROW_KEY_ONE,   KeyTilde, ACT_ECHO,    KeyTilde},
      '{ROW_KEY_ONE,   KeyErase, ACT_RUBOUT,  8'h00},
      '{ROW_KEY_MODEL, KeyWord,  ACT_ECHO,    8'h00},     // trailing space then word
      '{ROW_KEY_NONE,  KeyKill,  ACT_ECHO,    8'h00},     // kill on empty line
      // narrowest wrap, prompt at the far right
      '{ROW_WRAP,      8'd2,     ACT_ECHO,    8'h00},
      '{ROW_START,     8'd63,    ACT_ECHO,    8'h00},
      '{ROW_KEY_MODEL, 8'h61,    ACT_ECHO,    8'h00},     // wrap without a space
      '{ROW_KEY_ONE,   8'h62,    ACT_ECHO,    8'h62},
      '{ROW_KEY_MODEL, KeySpace, ACT_ECHO,    8'h00},     // space wraps, empty word
      '{ROW_KEY_ONE,   KeyErase, ACT_RUBOUT,  8'h00},     // column stays at zero
      '{ROW_KEY_ONE,   KeySpace, ACT_ECHO,    KeySpace},
      '{ROW_KEY_ONE,   8'h63,    ACT_ECHO,    8'h63},
      '{ROW_KEY_MODEL, 8'h64,    ACT_ECHO,    8'h00},     // word too long to replay
      '{ROW_KEY_MODEL, KeyKill,  ACT_ECHO,    8'h00}
    };

    // session end is final, so it only comes at the very end
    closing = '{
      '{ROW_KEY_MODEL, KeyKill,  ACT_ECHO,    8'h00},
      '{ROW_KEY_ONE,   KeyEnd,   ACT_END,     8'h00},
      '{ROW_KEY_NONE,  8'h78,    ACT_ECHO,    8'h00},     // swallowed after end
      '{ROW_KEY_NONE,  KeyEnd,   ACT_ECHO,    8'h00}
    };

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_rows(opening);

    // random phases, each with its own settings and sink pattern
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       begin wrap_val = 6'd63; start_val = 6'd0;  end
        1:       begin wrap_val = 6'd63; start_val = 6'd63; end
        2:       begin wrap_val = 6'd2;  start_val = 6'd0;  end
        default: begin
          wrap_val  = 6'($urandom_range(2, $urandom_range(0, 1) ? 12 : 63));
          start_val = 6'($urandom_range(0, 63));
        end
      endcase
      wait_idle();
      cfg_write(CFG_WRAP_WIDTH, wrap_val);
      cfg_write(CFG_START_COLUMN, start_val);
      sink_mode = (phase == 0) ? SINK_STEADY : sink_mode_e'($urandom_range(0, 2));

      // fill the store past its depth to hit the full-store bell
      if (phase == 3 || phase == 6) begin
        send_key(KeyKill);
        repeat (FillKeys)
          send_key(($urandom_range(0, 5) == 0) ? KeySpace
                                               : 8'($urandom_range(8'h21, KeyTilde)));
      end

      phase_base = keys_sent;
      while (keys_sent - phase_base < PhaseKeys) type_random();
    end

    run_rows(closing);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lnedit_pkg.sv
src/lnedit_if.sv
src/lnedit_front.sv
src/lnedit_queue.sv
src/lnedit_back.sv
src/line_editor_with_word_wrap.sv
dv/tb.sv
